### sv/viewport_follow_deadzone_macros.svh
// Assertion shorthands for the viewport follow block.
// They expect i_clk and i_rst_n in the scope where they are used.
`ifndef VIEWPORT_FOLLOW_DEADZONE_MACROS_SVH
`define VIEWPORT_FOLLOW_DEADZONE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vfd_pkg.sv
package vfd_pkg;

    // Working width for position arithmetic: holds sums of two map
    // coordinates plus a view size with sign to spare.
    localparam int POS_W = 20;
    typedef logic signed [POS_W-1:0] t_pos;

    // Viewport corner as it leaves the block.
    typedef logic signed [15:0] t_view;

    typedef logic [14:0] t_coord;
    typedef logic [11:0] t_size;
    typedef logic [1:0]  t_mode;
    typedef logic [2:0]  t_reg_idx;

    // Follow modes.
    localparam t_mode MODE_CENTRE    = 2'd0;
    localparam t_mode MODE_DEADZONE  = 2'd1;
    localparam t_mode MODE_DIRECTION = 2'd2;

    // Configuration register indexes.
    localparam t_reg_idx REG_FOLLOW_MODE = 3'd0;
    localparam t_reg_idx REG_MAP_WIDTH   = 3'd1;
    localparam t_reg_idx REG_MAP_HEIGHT  = 3'd2;
    localparam t_reg_idx REG_VIEW_WIDTH  = 3'd3;
    localparam t_reg_idx REG_VIEW_HEIGHT = 3'd4;

    localparam int CFG_DATA_W = 15;

    localparam t_size VIEW_WIDTH_RST  = 12'd640;
    localparam t_size VIEW_HEIGHT_RST = 12'd480;

    function automatic t_pos ext_coord(input t_coord v);
        return t_pos'({{(POS_W-15){1'b0}}, v});
    endfunction

    function automatic t_pos ext_size(input t_size v);
        return t_pos'({{(POS_W-12){1'b0}}, v});
    endfunction

    // Keep the view corner on the map; with a map smaller than the view
    // the upper limit goes negative and wins for any value from zero up.
    function automatic t_pos clamp_map(input t_pos v, input t_pos map, input t_pos view);
        t_pos lim;
        lim = map - view;
        if (v < 0) begin
            return '0;
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    // Centre the view on the target, limiting the target first when the
    // map size is known.
    function automatic t_pos centre_axis(input t_pos t, input t_pos map, input t_pos view);
        t_pos half;
        t_pos tt;
        half = view >>> 1;
        tt   = t;
        if (map != 0) begin
            if (tt + half > map) begin
                tt = map - half;
            end
            if (tt < half) begin
                tt = half;
            end
        end
        return tt - half;
    endfunction

endpackage

### sv/viewport_follow_deadzone.sv
// An accepted item passes through the input register, then the result register,
// where it waits until it is taken; throughput is one item per cycle while the
// output is not stalled.
// The loop that sets the rate is the viewport state update, closed through the result register.
// Reset (synchronous, active low) clears both handshake stages, the viewport
// corner and the remembered target, and loads the register reset values.
module viewport_follow_deadzone #(
    parameter int DEADZONE_W = 128,
    parameter int DEADZONE_H = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  vfd_pkg::t_reg_idx             i_cfg_idx,
    input  logic [vfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Target position items.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  vfd_pkg::t_coord               i_target_x,
    input  vfd_pkg::t_coord               i_target_y,
    // Viewport result items.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output vfd_pkg::t_view                o_view_left,
    output vfd_pkg::t_view                o_view_top,
    output logic                          o_moved
);
    import vfd_pkg::*;

    // Dead-zone sizes in the working width. Direction mode halves them
    // before subtracting, which is fixed at elaboration.
    localparam t_pos DZW      = t_pos'(DEADZONE_W);
    localparam t_pos DZH      = t_pos'(DEADZONE_H);
    localparam t_pos DZW_HALF = t_pos'(DEADZONE_W / 2);
    localparam t_pos DZH_HALF = t_pos'(DEADZONE_H / 2);

    // Configuration registers.
    t_mode  r_mode;
    t_coord r_map_w;
    t_coord r_map_h;
    t_size  r_view_w;
    t_size  r_view_h;

    // Input stage.
    logic   r_in_vld;
    t_coord r_tx;
    t_coord r_ty;

    // Result stage. The viewport corner shown at the output is also the
    // follow state: it always equals the last computed corner, and reset
    // puts it at the origin.
    logic   r_out_vld;
    t_view  r_cur_left;
    t_view  r_cur_top;
    logic   r_moved;

    // Target seen on the previous direction-mode item.
    t_coord r_prev_x;
    t_coord r_prev_y;
    logic   r_prev_vld;

    logic   adv;
    logic   in_acc;

    // The result stage takes the pending item when it is empty or when
    // its current item leaves in this same cycle. The input stage can
    // then take a new item even while a result is stalled at the output.
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_vld;
    assign o_view_left = r_cur_left;
    assign o_view_top  = r_cur_top;
    assign o_moved     = r_moved;

    // ------------------------------------------------------------------
    // Position update: one pass of compares, adds and clamps on the held
    // item and the current corner.
    // ------------------------------------------------------------------
    t_pos x, y, px, py;
    t_pos cl, ct;
    t_pos mw, mh, vw, vh;
    t_pos dw, dh, ix1, iy1;
    t_pos dz_l, dz_t, nl1, nt1;
    t_pos hw, hh, ix2, iy2;
    t_pos dir_l, dir_t;
    t_pos cen_l, cen_t;
    t_pos nl, nt;
    logic edge_cur, edge_prev, out_box;
    t_view n_left, n_top;
    logic  n_moved;

    always_comb begin
        x  = ext_coord(r_tx);
        y  = ext_coord(r_ty);
        cl = t_pos'(r_cur_left);
        ct = t_pos'(r_cur_top);
        mw = ext_coord(r_map_w);
        mh = ext_coord(r_map_h);
        vw = ext_size(r_view_w);
        vh = ext_size(r_view_h);

        // Centre mode.
        cen_l = centre_axis(x, mw, vw);
        cen_t = centre_axis(y, mh, vh);

        // Dead-zone mode: the margin is (view - dead zone) / 2, rounded
        // toward zero, so a negative difference is bumped up before the
        // arithmetic shift.
        dw  = vw - DZW;
        dh  = vh - DZH;
        ix1 = (dw + ((dw < 0) ? t_pos'(1) : t_pos'(0))) >>> 1;
        iy1 = (dh + ((dh < 0) ? t_pos'(1) : t_pos'(0))) >>> 1;
        nl1 = cl;
        nt1 = ct;
        if (x < cl + ix1) begin
            nl1 = x - ix1;
        end else if (x > cl + vw - ix1) begin
            nl1 = x + ix1 - vw;
        end
        if (y < ct + iy1) begin
            nt1 = y - iy1;
        end else if (y > ct + vh - iy1) begin
            nt1 = y + iy1 - vh;
        end
        dz_l = clamp_map(nl1, mw, vw);
        dz_t = clamp_map(nt1, mh, vh);

        // Direction mode. Without a remembered target the current one
        // stands in, which makes the motion zero.
        px = r_prev_vld ? ext_coord(r_prev_x) : x;
        py = r_prev_vld ? ext_coord(r_prev_y) : y;
        hw = vw >>> 1;
        hh = vh >>> 1;
        edge_cur  = (x < hw) || (x > mw - hw) || (y < hh) || (y > mh - hh);
        edge_prev = (px < hw) || (px > mw - hw) || (py < hh) || (py > mh - hh);
        ix2 = hw - DZW_HALF;
        iy2 = hh - DZH_HALF;
        out_box = (x < cl + ix2) || (x > cl + vw - ix2) ||
                  (y < ct + iy2) || (y > ct + vh - iy2);
        if (edge_cur || edge_prev) begin
            dir_l = dz_l;
            dir_t = dz_t;
        end else if (out_box) begin
            dir_l = clamp_map(cl + x - px, mw, vw);
            dir_t = clamp_map(ct + y - py, mh, vh);
        end else begin
            dir_l = cl;
            dir_t = ct;
        end

        case (r_mode)
            MODE_CENTRE: begin
                nl = cen_l;
                nt = cen_t;
            end
            MODE_DEADZONE: begin
                nl = dz_l;
                nt = dz_t;
            end
            MODE_DIRECTION: begin
                nl = dir_l;
                nt = dir_t;
            end
            default: begin
                // The unused mode code holds the view where it is.
                nl = cl;
                nt = ct;
            end
        endcase

        // Every mode lands within 16 bits.
        n_left  = t_view'(nl[15:0]);
        n_top   = t_view'(nt[15:0]);
        n_moved = (n_left != r_cur_left) || (n_top != r_cur_top);
    end

    // ------------------------------------------------------------------
    // Configuration registers. Write only while the block is idle; not enforced.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CENTRE;
            r_map_w  <= '0;
            r_map_h  <= '0;
            r_view_w <= VIEW_WIDTH_RST;
            r_view_h <= VIEW_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FOLLOW_MODE: r_mode   <= t_mode'(i_cfg_data[1:0]);
                REG_MAP_WIDTH:   r_map_w  <= t_coord'(i_cfg_data[14:0]);
                REG_MAP_HEIGHT:  r_map_h  <= t_coord'(i_cfg_data[14:0]);
                REG_VIEW_WIDTH:  r_view_w <= t_size'(i_cfg_data[11:0]);
                REG_VIEW_HEIGHT: r_view_h <= t_size'(i_cfg_data[11:0]);
                default: begin
                    // Writes to indexes past the list are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tx <= i_target_x;
            r_ty <= i_target_y;
        end
    end

    // ------------------------------------------------------------------
    // Result stage and follow state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_cur_left <= '0;
            r_cur_top  <= '0;
            r_moved    <= 1'b0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_out_vld  <= 1'b1;
                r_cur_left <= n_left;
                r_cur_top  <= n_top;
                r_moved    <= n_moved;
                // Only direction mode remembers the target.
                if (r_mode == MODE_DIRECTION) begin
                    r_prev_x   <= r_tx;
                    r_prev_y   <= r_ty;
                    r_prev_vld <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

### sv/vfd_checker.sv
`include "viewport_follow_deadzone_macros.svh"

module vfd_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input vfd_pkg::t_view  o_view_left,
    input vfd_pkg::t_view  o_view_top,
    input logic            o_moved
);
    import vfd_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_view      r_last_left;
    t_view      r_last_top;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Items inside the block: accepted but not yet delivered.
    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_last_left <= '0;
            r_last_top  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (out_acc) begin
                r_last_left <= o_view_left;
                r_last_top  <= o_view_top;
            end
        end
    end

    `VFD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_view_left) && $stable(o_view_top) && $stable(o_moved), "stalled result changed")
    `VFD_ASSERT_IMP(a_no_phantom, o_out_valid, r_cnt != 2'd0, "result without an item inside")
    `VFD_ASSERT_IMP(a_capacity, !o_in_ready, r_cnt == 2'd2, "input blocked before both stages are full")
    `VFD_ASSERT_IMP(a_moved_flag, o_out_valid, o_moved == ((o_view_left != r_last_left) || (o_view_top != r_last_top)), "moved flag disagrees with the corner")

endmodule

bind viewport_follow_deadzone vfd_checker u_vfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_view_left (o_view_left),
    .o_view_top  (o_view_top),
    .o_moved     (o_moved)
);

### dv/tb_viewport_follow_deadzone.sv
module tb_viewport_follow_deadzone;
    timeunit 1ns;
    timeprecision 1ps;

    import vfd_pkg::*;

    // Dead-zone box size; the instance gets the same values.
    localparam int DZ_W = 128;
    localparam int DZ_H = 64;

    // The follow mode register is two bits wide, and the code that the package
    // leaves unnamed holds the view in place.
    localparam t_mode MODE_HOLD = 2'd3;

    localparam int COORD_MAX   = 32767;
    localparam int SIZE_MAX    = 4095;
    // An item passes the input and result registers before its result can be
    // taken, so these spare cycles are enough to be sure the pipeline is empty.
    localparam int SETTLE_CYC  = 4;
    localparam int DRAIN_MAX   = 20000;
    localparam int LONG_HOLD   = 400;
    localparam int PRINT_LIMIT = 50;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 65;
    // Longest idle burst on either side, in cycles.
    localparam int BURST_MAX   = 18;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } target_t;

    typedef struct packed {
        t_view left;
        t_view top;
        logic  moved;
    } view_res_t;

    // Clock, reset and every block input start at a known value.
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       cfg_we    = 1'b0;
    t_reg_idx   cfg_idx   = REG_FOLLOW_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic       in_valid  = 1'b0;
    t_coord     in_x      = '0;
    t_coord     in_y      = '0;
    logic       out_ready = 1'b0;

    logic       in_ready;
    logic       out_valid;
    t_view      out_left;
    t_view      out_top;
    logic       out_moved;

    viewport_follow_deadzone #(
        .DEADZONE_W (DZ_W),
        .DEADZONE_H (DZ_H)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_target_x  (in_x),
        .i_target_y  (in_y),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_view_left (out_left),
        .o_view_top  (out_top),
        .o_moved     (out_moved)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Items waiting to be offered, and the viewport results still owed by the block.
    target_t   target_q[$];
    view_res_t view_due_q[$];

    int mismatch_cnt = 0;

    // Idling controls, written only by the stimulus sequence.
    int gap_pct        = 0;
    int stall_pct      = 0;
    bit want_long_hold = 1'b0;

    // Shadow copy of the configuration registers.
    t_mode cfg_mode   = MODE_CENTRE;
    int    cfg_map_w  = 0;
    int    cfg_map_h  = 0;
    int    cfg_view_w = int'(VIEW_WIDTH_RST);
    int    cfg_view_h = int'(VIEW_HEIGHT_RST);

    // Shadow copy of the viewport corner and of the target remembered by the
    // direction mode. Only the direction mode touches the remembered target.
    int view_l    = 0;
    int view_t    = 0;
    int last_tx   = 0;
    int last_ty   = 0;
    bit last_seen = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Viewport predictor
    // ------------------------------------------------------------------

    // Keeps the corner on the map. A map smaller than the view makes the
    // upper limit negative, and that limit then wins for any value from zero up.
    function automatic int fit_map(input int v, input int map, input int view);
        if (v < 0) begin
            return 0;
        end
        if (v > map - view) begin
            return map - view;
        end
        return v;
    endfunction

    // Centre mode for one axis. A map size of zero means no limit on the target.
    function automatic int centre_on(input int t, input int map, input int view);
        int half;
        int tt;
        half = view / 2;
        tt   = t;
        if (map != 0) begin
            if (tt + half > map) begin
                tt = map - half;
            end
            if (tt < half) begin
                tt = half;
            end
        end
        return tt - half;
    endfunction

    // Dead-zone follow. The margin is (view - box)/2 with the division
    // truncated toward zero, which matters once the view is smaller than the box.
    function automatic void deadzone_move(input int x, input int y,
                                          output int nl, output int nt);
        int ix;
        int iy;
        int l;
        int t;
        ix = (cfg_view_w - DZ_W) / 2;
        iy = (cfg_view_h - DZ_H) / 2;
        l  = view_l;
        t  = view_t;
        if (x < view_l + ix) begin
            l = x - ix;
        end else if (x > view_l + cfg_view_w - ix) begin
            l = x + ix - cfg_view_w;
        end
        if (y < view_t + iy) begin
            t = y - iy;
        end else if (y > view_t + cfg_view_h - iy) begin
            t = y + iy - cfg_view_h;
        end
        nl = fit_map(l, cfg_map_w, cfg_view_w);
        nt = fit_map(t, cfg_map_h, cfg_view_h);
    endfunction

    function automatic bit edge_near(input int x, input int y, input int hw, input int hh);
        return (x < hw) || (x > cfg_map_w - hw) || (y < hh) || (y > cfg_map_h - hh);
    endfunction

    // Direction mode: shift by the target's own motion once it leaves the
    // inner box, with the dead-zone rule near the map edges.
    function automatic void direction_move(input int x, input int y,
                                           output int nl, output int nt);
        int hw;
        int hh;
        int ix;
        int iy;
        hw = cfg_view_w / 2;
        hh = cfg_view_h / 2;
        if (!last_seen) begin
            last_tx = x;
            last_ty = y;
        end
        if (edge_near(x, y, hw, hh) || edge_near(last_tx, last_ty, hw, hh)) begin
            deadzone_move(x, y, nl, nt);
        end else begin
            ix = hw - DZ_W / 2;
            iy = hh - DZ_H / 2;
            nl = view_l;
            nt = view_t;
            if (x < view_l + ix || x > view_l + cfg_view_w - ix ||
                y < view_t + iy || y > view_t + cfg_view_h - iy) begin
                nl = fit_map(view_l + x - last_tx, cfg_map_w, cfg_view_w);
                nt = fit_map(view_t + y - last_ty, cfg_map_h, cfg_view_h);
            end
        end
        last_tx   = x;
        last_ty   = y;
        last_seen = 1'b1;
    endfunction

    // Works out the viewport result of one accepted item and queues it.
    task automatic predict_view(input t_coord tx, input t_coord ty);
        int        x;
        int        y;
        int        nl;
        int        nt;
        view_res_t res;
        x  = int'(tx);
        y  = int'(ty);
        nl = view_l;
        nt = view_t;
        case (cfg_mode)
            MODE_CENTRE: begin
                nl = centre_on(x, cfg_map_w, cfg_view_w);
                nt = centre_on(y, cfg_map_h, cfg_view_h);
            end
            MODE_DEADZONE: begin
                deadzone_move(x, y, nl, nt);
            end
            MODE_DIRECTION: begin
                direction_move(x, y, nl, nt);
            end
            default: begin
                // Hold mode keeps the corner and all other state.
            end
        endcase
        res.left  = t_view'(nl[15:0]);
        res.top   = t_view'(nt[15:0]);
        res.moved = (nl != view_l) || (nt != view_t);
        view_l = nl;
        view_t = nt;
        view_due_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers items from target_q at the falling edge, with random
    // gaps between items. An item stays on the bus until it is taken.
    // ------------------------------------------------------------------

    // Whether the item on the bus was taken at the last rising edge.
    logic in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken <= in_valid && in_ready;
    end

    int in_gap = 0;

    always @(negedge i_clk) begin : sender
        logic    nv;
        target_t item;
        nv   = in_valid;
        item = '{x: in_x, y: in_y};
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!in_valid || in_taken) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (target_q.size() > 0) begin
                if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
                    // This cycle is the first idle one of the burst.
                    in_gap = $urandom_range(18, 1) - 1;
                end else begin
                    item = target_q.pop_front();
                    nv   = 1'b1;
                end
            end
        end
        in_valid <= nv;
        in_x     <= item.x;
        in_y     <= item.y;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, and once a long hold-off that lets the
    // block fill up while the sender keeps offering.
    // ------------------------------------------------------------------

    int  stall_cnt = 0;
    int  hold_cnt  = 0;
    bit  hold_done = 1'b0;

    always @(negedge i_clk) begin : receiver
        logic nr;
        if (hold_cnt > 0) begin
            hold_cnt--;
            nr = 1'b0;
        end else if (want_long_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = LONG_HOLD - 1;
            nr        = 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            nr = 1'b0;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            stall_cnt = $urandom_range(18, 1) - 1;
            nr        = 1'b0;
        end else begin
            nr = 1'b1;
        end
        out_ready <= nr;
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result taken against the oldest prediction,
    // then predicts the item taken at the same edge. A result is always
    // older than an item taken with it, so this order is safe.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        view_res_t due;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (view_due_q.size() == 0) begin
                    report_mismatch("viewport result with no item waiting for one");
                end else begin
                    due = view_due_q.pop_front();
                    if (out_left !== due.left) begin
                        report_mismatch($sformatf("view_left %0d, wanted %0d",
                                                  out_left, due.left));
                    end
                    if (out_top !== due.top) begin
                        report_mismatch($sformatf("view_top %0d, wanted %0d",
                                                  out_top, due.top));
                    end
                    if (out_moved !== due.moved) begin
                        report_mismatch($sformatf("moved %b, wanted %b",
                                                  out_moved, due.moved));
                    end
                end
            end
            if (in_valid && in_ready) begin
                predict_view(in_x, in_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------

    // Writes one register at a falling edge and keeps the shadow copy in step.
    // Only called while the block is idle.
    task automatic set_reg(input t_reg_idx idx, input int val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val[CFG_DATA_W-1:0];
        case (idx)
            REG_FOLLOW_MODE: cfg_mode   = t_mode'(val[1:0]);
            REG_MAP_WIDTH:   cfg_map_w  = val & 32'h7FFF;
            REG_MAP_HEIGHT:  cfg_map_h  = val & 32'h7FFF;
            REG_VIEW_WIDTH:  cfg_view_w = val & 32'hFFF;
            REG_VIEW_HEIGHT: cfg_view_h = val & 32'hFFF;
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_sizes(input int mw, input int mh, input int vw, input int vh);
        set_reg(REG_MAP_WIDTH, mw);
        set_reg(REG_MAP_HEIGHT, mh);
        set_reg(REG_VIEW_WIDTH, vw);
        set_reg(REG_VIEW_HEIGHT, vh);
    endtask

    task automatic push_target(input int x, input int y);
        target_q.push_back('{x: t_coord'(x), y: t_coord'(y)});
    endtask

    // Waits until every item has been taken and every result has come back,
    // then lets the pipeline settle, and returns at a falling edge.
    task automatic wait_idle();
        int n;
        n = 0;
        do begin
            @(posedge i_clk);
            #1;
            n++;
        end while ((target_q.size() != 0 || in_valid || view_due_q.size() != 0) &&
                   n < DRAIN_MAX);
        if (view_due_q.size() != 0 || target_q.size() != 0) begin
            report_mismatch($sformatf("%0d viewport results never arrived",
                                      view_due_q.size()));
            view_due_q.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int clip_coord(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        return v;
    endfunction

    // Queues a random walk of the target: mostly small steps, so the
    // follow modes see a plausible motion and the direction mode gets past
    // its edge fallback, with some jumps anywhere and to the corners.
    task automatic queue_walk(input int n, input int span);
        int k;
        int pick;
        int x;
        int y;
        x = (cfg_map_w > 0) ? int'($urandom_range(cfg_map_w)) : int'($urandom_range(COORD_MAX));
        y = (cfg_map_h > 0) ? int'($urandom_range(cfg_map_h)) : int'($urandom_range(COORD_MAX));
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                x = $urandom_range(COORD_MAX);
                y = $urandom_range(COORD_MAX);
            end else if (pick < 12) begin
                x = $urandom_range(1) * COORD_MAX;
                y = $urandom_range(1) * COORD_MAX;
            end else begin
                x = clip_coord(x + int'($urandom_range(2 * span)) - span);
                y = clip_coord(y + int'($urandom_range(2 * span)) - span);
            end
            push_target(x, y);
        end
    endtask

    function automatic int pick_map();
        case ($urandom_range(7))
            0:       return 0;
            1:       return COORD_MAX;
            2:       return $urandom_range(2000, 1);
            default: return $urandom_range(COORD_MAX, 4000);
        endcase
    endfunction

    function automatic int pick_view(input int usual);
        case ($urandom_range(7))
            0:       return 1;
            1:       return SIZE_MAX;
            2:       return usual;
            default: return $urandom_range(1500, 64);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    initial begin : stimulus
        int ph;
        int r;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. The reset configuration is centre mode with no map,
        // so the first items are centred with no clamp at all.
        gap_pct   = 20;
        stall_pct = 20;
        push_target(0, 0);
        push_target(COORD_MAX, COORD_MAX);
        push_target(21845, 10922);
        wait_idle();

        // Centre mode on the largest map with the largest view.
        set_sizes(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
        push_target(0, 0);
        push_target(COORD_MAX, COORD_MAX);
        push_target(5000, 30000);
        wait_idle();

        // Dead-zone mode on a map smaller than the view: the clamp goes negative.
        set_reg(REG_FOLLOW_MODE, int'(MODE_DEADZONE));
        set_sizes(100, 60, 640, 480);
        push_target(0, 0);
        push_target(COORD_MAX, COORD_MAX);
        wait_idle();

        // Dead-zone mode on a roomy map: stay inside the box, then leave it
        // on each side.
        set_sizes(4000, 3000, 640, 480);
        push_target(320, 240);
        push_target(330, 250);
        push_target(10, 5);
        push_target(3990, 2990);
        push_target(2000, 1500);
        wait_idle();

        // Direction mode: first tick with no remembered target, a small move
        // inside the box, a jump out of it, a trip near the edge and back.
        set_reg(REG_FOLLOW_MODE, int'(MODE_DIRECTION));
        set_sizes(8000, 8000, 640, 480);
        push_target(4000, 4000);
        push_target(4010, 4000);
        push_target(4500, 4300);
        push_target(100, 100);
        push_target(4000, 4000);
        push_target(4005, 4003);
        wait_idle();

        // The unused mode code holds the view.
        set_reg(REG_FOLLOW_MODE, int'(MODE_HOLD));
        push_target(1234, 4321);
        push_target(0, COORD_MAX);
        wait_idle();

        // The smallest view, smaller than the dead-zone box, with no map.
        set_reg(REG_FOLLOW_MODE, int'(MODE_DEADZONE));
        set_sizes(0, 0, 1, 1);
        push_target(7, 9);
        push_target(COORD_MAX, 0);
        wait_idle();

        // Random part: each phase picks a configuration and idling pattern,
        // queues a target walk, and drains before the next setting.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES - 1) begin
                // The closing stretch runs with no idling on either side;
                // any burst still running dies out before its items come.
                gap_pct   = 0;
                stall_pct = 0;
                repeat (BURST_MAX) @(negedge i_clk);
            end else begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            r = $urandom_range(15);
            if (r < 4) begin
                set_reg(REG_FOLLOW_MODE, int'(MODE_CENTRE));
            end else if (r < 9) begin
                set_reg(REG_FOLLOW_MODE, int'(MODE_DEADZONE));
            end else if (r < 15) begin
                set_reg(REG_FOLLOW_MODE, int'(MODE_DIRECTION));
            end else begin
                set_reg(REG_FOLLOW_MODE, int'(MODE_HOLD));
            end
            set_sizes(pick_map(), pick_map(), pick_view(640), pick_view(480));
            queue_walk(PHASE_ITEMS, $urandom_range(400, 1));
            if (ph == RAND_PHASES / 2) begin
                // The receiver holds off for a long stretch so the block
                // backs up into the sender.
                want_long_hold = 1'b1;
            end
            wait_idle();
        end

        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard limit, far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
